// ===== hw/rtl/set_assoc_lru_writeback_cache_assert.svh =====
// assertion macros for the cache controller, clocked on clk, disabled in reset
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_ASSERT_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SALWC_ASSERT_IMP(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("cache controller check failed");
`define SALWC_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("cache controller check failed");
`else
`define SALWC_ASSERT_IMP(lbl, cond, prop)
`define SALWC_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

// ===== hw/rtl/salwc_pkg.sv =====
package salwc_pkg;

	localparam int DIV_W = 32;
	localparam int DSR_W = 9;

	// memory operation codes
	localparam logic OP_FETCH = 1'b0;
	localparam logic OP_WB    = 1'b1;

	// configuration register indexes
	localparam logic REG_WAYS = 1'b0;
	localparam logic REG_SETS = 1'b1;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
		logic [DSR_W-1:0] rem;
	} div_rsp_t;

endpackage

// ===== hw/rtl/salwc_ram.sv =====
module salwc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/salwc_div.sv =====
module salwc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  salwc_pkg::div_req_t req,
	output salwc_pkg::div_rsp_t rsp
);

	logic [salwc_pkg::DIV_W-1:0] q_q;
	logic [salwc_pkg::DSR_W-1:0] r_q;
	logic [salwc_pkg::DSR_W-1:0] d_q;
	logic [4:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [salwc_pkg::DSR_W:0]   cand;
	logic                        ge;
	logic [salwc_pkg::DSR_W:0]   diff;

	// one quotient bit per cycle, restoring
	assign cand = {r_q, q_q[salwc_pkg::DIV_W-1]};
	assign ge   = cand >= {1'b0, d_q};
	assign diff = cand - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == 5'(salwc_pkg::DIV_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(salwc_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.dividend;
			r_q <= '0;
			d_q <= req.divisor;
		end else if (busy_q) begin
			q_q <= {q_q[salwc_pkg::DIV_W-2:0], ge};
			r_q <= ge ? diff[salwc_pkg::DSR_W-1:0] : cand[salwc_pkg::DSR_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = q_q;
	assign rsp.rem  = r_q;

endmodule

// ===== hw/rtl/set_assoc_lru_writeback_cache.sv =====
// set-associative write-back cache controller with lru replacement
// input channel s_axis: one word per access, tdata = block number, tuser = write flag
// output channel m_axis: memory operations, tdata = block, tuser = op (0 fetch,
// 1 write back), tlast marks the final operation of an access; a hit gives none
// config channel cfg: index 0 writes ways in use, index 1 writes sets in use,
// always ready, meant to be written while the controller is idle
// sequence: the set index takes two passes of one shared shift-subtract divider
// (block / ways, then quotient mod sets), then one ram read, a scan of the tag and
// age of each way in use in turn (a hit stops it early), and one update step, after
// which the controller is ready again; a write back going out first adds one fetch
// step before that; one access at a time
// throughput is bound by the divider; s_axis_tready is high only when idle
// reset: after arst_n releases, the controller sweeps the state ram once,
// clearing valid, dirty and age; no access is taken meanwhile
// stall: results sit in one output register; a write back waits there until taken
// before the fetch is loaded, and the next access may start while the last
// result of the previous one is still waiting
`include "set_assoc_lru_writeback_cache_assert.svh"

module set_assoc_lru_writeback_cache #(
	parameter int WAYS       = 8,
	parameter int SETS       = 256,
	parameter int BLOCK_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] block_number
	input  logic        s_axis_tuser,  // [0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] mem_block
	output logic        m_axis_tuser,  // [0] mem_op
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int AW     = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WIX    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int AGE_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int TAG_W  = (BLOCK_BITS < 32) ? BLOCK_BITS : 32;
	localparam int META_W = WAYS * (2 + AGE_W);
	localparam int ROW_W  = WAYS * TAG_W;
	localparam logic [AGE_W-1:0] AMAX = AGE_W'(WAYS - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIVW  = 3'd2;
	localparam logic [2:0] ST_DIVS  = 3'd3;
	localparam logic [2:0] ST_RD    = 3'd4;
	localparam logic [2:0] ST_SCAN  = 3'd5;
	localparam logic [2:0] ST_UPD   = 3'd6;
	localparam logic [2:0] ST_FETCH = 3'd7;

	logic [2:0] state_q;
	logic [3:0] ways_q;
	logic [8:0] sets_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] set_q;
	logic          wr_q;
	logic [TAG_W-1:0] blk_q;

	// scan results
	logic [WIX-1:0]   wc_q;
	logic             hit_q;
	logic [WIX-1:0]   hit_way_q;
	logic             free_q;
	logic [WIX-1:0]   free_way_q;
	logic [WIX-1:0]   best_way_q;
	logic [AGE_W-1:0] best_age_q;

	// output register
	logic        out_valid_q;
	logic        out_op_q;
	logic [31:0] out_blk_q;
	logic        out_last_q;

	logic [6:0]  w_eff;
	logic [16:0] s_eff;
	logic        in_acc;
	logic        load_ok;
	logic        out_load;

	salwc_pkg::div_req_t div_req;
	salwc_pkg::div_rsp_t div_rsp;

	logic              meta_we;
	logic [AW-1:0]     meta_waddr;
	logic [META_W-1:0] meta_wdata;
	logic [META_W-1:0] meta_rdata;
	logic              tag_we;
	logic [ROW_W-1:0]  tag_wdata;
	logic [ROW_W-1:0]  tag_rdata;

	logic [WAYS-1:0]       valid_v;
	logic [WAYS-1:0]       dirty_v;
	logic [WAYS*AGE_W-1:0] age_v;
	logic [WAYS-1:0]       nvalid_v;
	logic [WAYS-1:0]       ndirty_v;
	logic [WAYS*AGE_W-1:0] nage_v;

	logic [WIX-1:0]   slot;
	logic [AGE_W-1:0] slot_age;
	logic [TAG_W-1:0] slot_tag;
	logic             wb_need;
	logic             upd_go;
	logic [AGE_W-1:0] cur_age;
	logic             scan_end;
	logic [16:0]      set_wide;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign load_ok       = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_op_q;
	assign m_axis_tdata  = out_blk_q;
	assign m_axis_tlast  = out_last_q;

	// out-of-range register values clamp into range
	always_comb begin
		if (ways_q == 4'd0) begin
			w_eff = 7'd1;
		end else if (7'(ways_q) > 7'(WAYS)) begin
			w_eff = 7'(WAYS);
		end else begin
			w_eff = 7'(ways_q);
		end
		if (sets_q == 9'd0) begin
			s_eff = 17'd1;
		end else if (17'(sets_q) > 17'(SETS)) begin
			s_eff = 17'(SETS);
		end else begin
			s_eff = 17'(sets_q);
		end
	end

	// shared divider: block / ways, then quotient mod sets
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = 32'(s_axis_tdata[TAG_W-1:0]);
		div_req.divisor  = 9'(w_eff);
		if (in_acc) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_DIVW && div_rsp.done) begin
			div_req.start    = 1'b1;
			div_req.dividend = div_rsp.quo;
			div_req.divisor  = s_eff[8:0];
		end
	end

	salwc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign set_wide = 17'(div_rsp.rem);

	// row of valid, dirty and age for all ways of one set
	salwc_ram #(.WIDTH(META_W), .DEPTH(SETS)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (set_q),
		.rdata (meta_rdata)
	);

	// row of block numbers for all ways of one set, no reset needed
	salwc_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (set_q),
		.wdata (tag_wdata),
		.raddr (set_q),
		.rdata (tag_rdata)
	);

	assign valid_v = meta_rdata[WAYS-1:0];
	assign dirty_v = meta_rdata[2*WAYS-1:WAYS];
	assign age_v   = meta_rdata[META_W-1:2*WAYS];

	assign cur_age  = age_v[wc_q*AGE_W +: AGE_W];
	assign scan_end = (7'(wc_q) == w_eff - 7'd1);

	assign slot     = hit_q ? hit_way_q : (free_q ? free_way_q : best_way_q);
	assign slot_age = age_v[slot*AGE_W +: AGE_W];
	assign slot_tag = tag_rdata[slot*TAG_W +: TAG_W];
	assign wb_need  = !hit_q && !free_q && dirty_v[slot];
	assign upd_go   = (state_q == ST_UPD) && (hit_q || load_ok);
	assign out_load = (upd_go && !hit_q) || (state_q == ST_FETCH && load_ok);

	// new row contents: refresh the touched line, age the rest of the active ways
	always_comb begin
		nvalid_v = valid_v;
		ndirty_v = dirty_v;
		nage_v   = age_v;
		for (int i = 0; i < WAYS; i++) begin
			if (7'(i) < w_eff && valid_v[i] && age_v[i*AGE_W +: AGE_W] != AMAX) begin
				if (hit_q) begin
					if (age_v[i*AGE_W +: AGE_W] < slot_age) begin
						nage_v[i*AGE_W +: AGE_W] = age_v[i*AGE_W +: AGE_W] + AGE_W'(1);
					end
				end else if (WIX'(i) != slot) begin
					nage_v[i*AGE_W +: AGE_W] = age_v[i*AGE_W +: AGE_W] + AGE_W'(1);
				end
			end
		end
		nage_v[slot*AGE_W +: AGE_W] = '0;
		nvalid_v[slot] = 1'b1;
		ndirty_v[slot] = hit_q ? (dirty_v[slot] | wr_q) : wr_q;
	end

	always_comb begin
		tag_wdata = tag_rdata;
		tag_wdata[slot*TAG_W +: TAG_W] = blk_q;
	end

	assign meta_we    = (state_q == ST_CLEAR) || upd_go;
	assign meta_waddr = (state_q == ST_CLEAR) ? clr_q : set_q;
	assign meta_wdata = (state_q == ST_CLEAR) ? '0 : {nage_v, ndirty_v, nvalid_v};
	assign tag_we     = upd_go && !hit_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q <= 4'd8;
			sets_q <= 9'd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				salwc_pkg::REG_WAYS: ways_q <= cfg_data[3:0];
				salwc_pkg::REG_SETS: sets_q <= cfg_data;
				default:             ways_q <= ways_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (div_rsp.done) begin
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					if (div_rsp.done) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if ((valid_v[wc_q] && tag_rdata[wc_q*TAG_W +: TAG_W] == blk_q) || scan_end) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (upd_go) begin
						if (hit_q) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= wb_need ? ST_FETCH : ST_IDLE;
						end
					end
				end
				ST_FETCH: begin
					if (load_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			wr_q  <= s_axis_tuser;
			blk_q <= s_axis_tdata[TAG_W-1:0];
		end
		if (state_q == ST_DIVS && div_rsp.done) begin
			set_q <= set_wide[AW-1:0];
		end
		if (state_q == ST_RD) begin
			wc_q       <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			best_way_q <= '0;
			best_age_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			wc_q <= wc_q + WIX'(1);
			if (valid_v[wc_q] && tag_rdata[wc_q*TAG_W +: TAG_W] == blk_q) begin
				hit_q     <= 1'b1;
				hit_way_q <= wc_q;
			end
			if (!valid_v[wc_q] && !free_q) begin
				free_q     <= 1'b1;
				free_way_q <= wc_q;
			end
			// strict compare keeps the lowest way among equal ages
			if (wc_q == '0 || cur_age > best_age_q) begin
				best_way_q <= wc_q;
				best_age_q <= cur_age;
			end
		end
		if (upd_go && !hit_q) begin
			if (wb_need) begin
				out_op_q   <= salwc_pkg::OP_WB;
				out_blk_q  <= 32'(slot_tag);
				out_last_q <= 1'b0;
			end else begin
				out_op_q   <= salwc_pkg::OP_FETCH;
				out_blk_q  <= 32'(blk_q);
				out_last_q <= 1'b1;
			end
		end
		if (state_q == ST_FETCH && load_ok) begin
			out_op_q   <= salwc_pkg::OP_FETCH;
			out_blk_q  <= 32'(blk_q);
			out_last_q <= 1'b1;
		end
	end

	`SALWC_ASSERT_IMP(a_clear_blocks_input, state_q == ST_CLEAR, !s_axis_tready)
	`SALWC_ASSERT_IMP(a_wb_not_last, out_valid_q && out_op_q == salwc_pkg::OP_WB, !out_last_q)
	`SALWC_ASSERT_NEXT(a_wb_then_fetch, upd_go && wb_need, state_q == ST_FETCH)
	`SALWC_ASSERT_NEXT(a_sets_pass_to_read, state_q == ST_DIVS && div_rsp.done, state_q == ST_RD)

endmodule
